@@ hw/rtl/essp_pkg.sv @@
// essp_pkg: shared types and constants of the encoder stepped setpoint shifter
// used by essp_core, essp_ser and the top level; depends on nothing else
package essp_pkg;

  localparam int VALUE_BITS = 12;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int THR_W      = 8;
  localparam int CFG_W      = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;
  localparam int CFG_IDX_W  = 2;

  // operation codes
  localparam logic [1:0] OP_EDGE   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE    = 2'd3;

  // step selections
  localparam logic [1:0] SEL_FINE   = 2'd0;
  localparam logic [1:0] SEL_MEDIUM = 2'd1;
  localparam logic [1:0] SEL_COARSE = 2'd2;

  localparam logic [THR_W-1:0]      THR_RESET    = THR_W'(10);
  localparam logic [VALUE_BITS-1:0] FINE_RESET   = VALUE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] MEDIUM_RESET = VALUE_BITS'(10);
  localparam logic [VALUE_BITS-1:0] COARSE_RESET = VALUE_BITS'(100);
  localparam logic [THR_W-1:0]      CNT_MAX      = '1;

  // result descriptor handed from the state update to the serialiser
  typedef struct packed {
    logic                  load;
    logic                  send;
    logic [VALUE_BITS-1:0] value;
    logic [1:0]            step_idx;
  } desc_t;

endpackage

@@ hw/rtl/essp_core.sv @@
// essp_core: input register, configuration registers and setpoint state update
// depends on essp_pkg; feeds a result descriptor to essp_ser
module essp_core import essp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic                 phase_a,
  input  logic                 phase_b,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 desc_ready,
  output desc_t                desc
);

  logic                  in_vld;
  logic [1:0]            in_op;
  logic                  in_pa;
  logic                  in_pb;

  logic [THR_W-1:0]      threshold;
  logic [VALUE_BITS-1:0] fine_step;
  logic [VALUE_BITS-1:0] medium_step;
  logic [VALUE_BITS-1:0] coarse_step;

  logic [VALUE_BITS-1:0] setpoint_value;
  logic [1:0]            step_sel;
  logic [THR_W-1:0]      settle_cnt;
  logic [VALUE_BITS:0]   sent_value;

  logic [VALUE_BITS-1:0] setpoint_next;
  logic [1:0]            step_sel_next;
  logic [THR_W-1:0]      settle_cnt_next;
  logic [VALUE_BITS:0]   sent_value_next;

  logic                  advance;
  logic [VALUE_BITS-1:0] step;
  logic [VALUE_BITS:0]   up_sum;
  logic [THR_W-1:0]      cnt_inc;
  logic                  send;

  assign advance  = in_vld && desc_ready;
  assign in_stall = in_vld && !desc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_vld || advance) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op <= operation;
      in_pa <= phase_a;
      in_pb <= phase_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THR_RESET;
      fine_step   <= FINE_RESET;
      medium_step <= MEDIUM_RESET;
      coarse_step <= COARSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold   <= cfg_data[THR_W-1:0];
        REG_FINE:      fine_step   <= cfg_data[VALUE_BITS-1:0];
        REG_MEDIUM:    medium_step <= cfg_data[VALUE_BITS-1:0];
        REG_COARSE:    coarse_step <= cfg_data[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (step_sel)
      SEL_FINE:   step = fine_step;
      SEL_MEDIUM: step = medium_step;
      SEL_COARSE: step = coarse_step;
      default:    step = '0;
    endcase
  end

  assign up_sum  = {1'b0, setpoint_value} + {1'b0, step};
  assign cnt_inc = (settle_cnt == CNT_MAX) ? settle_cnt : settle_cnt + THR_W'(1);

  always_comb begin
    setpoint_next   = setpoint_value;
    step_sel_next   = step_sel;
    settle_cnt_next = settle_cnt;
    sent_value_next = sent_value;
    send            = 1'b0;
    case (in_op)
      OP_EDGE: begin
        // equal phase levels step up, unequal step down; out-of-range moves are dropped
        if (in_pa == in_pb) begin
          if (!up_sum[VALUE_BITS]) begin
            setpoint_next   = up_sum[VALUE_BITS-1:0];
            settle_cnt_next = '0;
          end
        end else if (setpoint_value >= step) begin
          setpoint_next   = setpoint_value - step;
          settle_cnt_next = '0;
        end
      end
      OP_BUTTON: begin
        step_sel_next   = (step_sel >= SEL_COARSE) ? SEL_FINE : step_sel + 2'd1;
        settle_cnt_next = '0;
      end
      OP_TICK: begin
        settle_cnt_next = cnt_inc;
        if (cnt_inc > threshold && {1'b0, setpoint_value} != sent_value) begin
          send            = 1'b1;
          settle_cnt_next = '0;
          sent_value_next = {1'b0, setpoint_value};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_value <= '0;
      step_sel       <= SEL_FINE;
      settle_cnt     <= '0;
      sent_value     <= {1'b1, {VALUE_BITS{1'b0}}};
    end else if (advance) begin
      setpoint_value <= setpoint_next;
      step_sel       <= step_sel_next;
      settle_cnt     <= settle_cnt_next;
      sent_value     <= sent_value_next;
    end
  end

  assign desc.load     = advance;
  assign desc.send     = send;
  assign desc.value    = setpoint_next;
  assign desc.step_idx = step_sel_next;

`ifndef SYNTHESIS
  a_step_sel_range: assert property (@(posedge clk) disable iff (rst)
    step_sel != 2'd3)
    else $error("step selection out of range");

  a_sent_after_send: assert property (@(posedge clk) disable iff (rst)
    advance && send |=> sent_value == {1'b0, setpoint_value} && settle_cnt == '0)
    else $error("send not recorded");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    in_vld && !advance |=> in_vld)
    else $error("input word lost while stalled");
`endif

endmodule

@@ hw/rtl/essp_ser.sv @@
// essp_ser: result register and msb-first shifter for the setpoint words
// depends on essp_pkg; takes descriptors from essp_core
module essp_ser import essp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  desc_t                 desc,
  output logic                  desc_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  serial_valid,
  output logic                  serial_bit,
  output logic                  last,
  output logic [VALUE_BITS-1:0] setpoint,
  output logic [1:0]            step_index
);

  logic                  busy;
  logic                  send;
  logic [VALUE_BITS-1:0] shreg;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] sp;
  logic [1:0]            si;
  logic                  taken;

  assign taken      = busy && !out_stall;
  assign last       = !send || (cnt == CNT_W'(VALUE_BITS - 1));
  assign desc_ready = !busy || (taken && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (desc.load) begin
      busy <= 1'b1;
    end else if (taken && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc.load) begin
      send  <= desc.send;
      shreg <= desc.value;
      sp    <= desc.value;
      si    <= desc.step_idx;
      cnt   <= '0;
    end else if (taken && !last) begin
      shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
      cnt   <= cnt + CNT_W'(1);
    end
  end

  assign out_valid    = busy;
  assign serial_valid = send;
  assign serial_bit   = send && shreg[VALUE_BITS-1];
  assign setpoint     = sp;
  assign step_index   = si;

`ifndef SYNTHESIS
  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    desc.load |-> desc_ready)
    else $error("descriptor loaded over a pending word");

  a_mid_shift_continues: assert property (@(posedge clk) disable iff (rst)
    taken && !last |=> busy && send && cnt == $past(cnt) + CNT_W'(1))
    else $error("shift sequence broken");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= CNT_W'(VALUE_BITS - 1))
    else $error("bit counter out of range");
`endif

endmodule

@@ hw/rtl/encoder_stepped_setpoint_shifter_top.sv @@
// an accepted word goes through the input register, then the result register
// throughput, while out_stall is low: one word per cycle when it yields a single
// result; a send yields twelve, one per cycle, set by the single result register
// reset (rst, synchronous): setpoint 0, fine step, settle count 0, nothing sent,
// registers back to threshold 10 and steps 1, 10, 100
module encoder_stepped_setpoint_shifter_top import essp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic                  phase_a,
  input  logic                  phase_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  serial_valid,
  output logic                  serial_bit,
  output logic                  last,
  output logic [VALUE_BITS-1:0] setpoint,
  output logic [1:0]            step_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  desc_t desc;
  logic  desc_ready;

  essp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .phase_a    (phase_a),
    .phase_b    (phase_b),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  essp_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .desc         (desc),
    .desc_ready   (desc_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .serial_valid (serial_valid),
    .serial_bit   (serial_bit),
    .last         (last),
    .setpoint     (setpoint),
    .step_index   (step_index)
  );

endmodule

@@ tb/setpoint_shift_checker.sv @@
// setpoint_shift_checker: watches the event, result and register ports of the
// setpoint shifter, predicts every result word and compares; needs essp_pkg
module setpoint_shift_checker import essp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic                  phase_a,
  input  logic                  phase_b,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  serial_valid,
  input  logic                  serial_bit,
  input  logic                  last,
  input  logic [VALUE_BITS-1:0] setpoint,
  input  logic [1:0]            step_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    mismatch_count,
  output int                    words_due
);

  typedef struct packed {
    logic                  carries_bit;
    logic                  data_bit;
    logic                  closes;
    logic [VALUE_BITS-1:0] value;
    logic [1:0]            sel;
  } serial_word_t;

  serial_word_t due_q[$];
  serial_word_t got, want;

  logic [THR_W-1:0]      threshold_r;
  logic [VALUE_BITS-1:0] fine_r, medium_r, coarse_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [1:0]            sel_r;
  logic [THR_W-1:0]      settle_r;
  logic [VALUE_BITS:0]   sent_r;

  // updates the setpoint state for one event and queues the words it yields
  function automatic void apply_event(input logic [1:0] op, input logic pa,
                                      input logic pb);
    logic [VALUE_BITS-1:0] step;
    logic [VALUE_BITS:0]   sum;
    serial_word_t          w;
    int                    i;
    case (op)
      OP_EDGE: begin
        step = (sel_r == SEL_FINE)   ? fine_r :
               (sel_r == SEL_MEDIUM) ? medium_r :
               (sel_r == SEL_COARSE) ? coarse_r : '0;
        if (pa == pb) begin
          sum = {1'b0, value_r} + {1'b0, step};
          if (!sum[VALUE_BITS]) begin
            value_r  = sum[VALUE_BITS-1:0];
            settle_r = '0;
          end
        end else if (value_r >= step) begin
          value_r  = value_r - step;
          settle_r = '0;
        end
      end
      OP_BUTTON: begin
        sel_r    = (sel_r >= SEL_COARSE) ? SEL_FINE : sel_r + 2'd1;
        settle_r = '0;
      end
      OP_TICK: begin
        if (settle_r != CNT_MAX) settle_r = settle_r + THR_W'(1);
        if (settle_r > threshold_r && {1'b0, value_r} != sent_r) begin
          // msb first, the closing flag only on the lsb
          for (i = VALUE_BITS - 1; i >= 0; i--) begin
            w = {1'b1, value_r[i], (i == 0), value_r, sel_r};
            due_q.push_back(w);
          end
          settle_r = '0;
          sent_r   = {1'b0, value_r};
          return;
        end
      end
      default: ;
    endcase
    w = {1'b0, 1'b0, 1'b1, value_r, sel_r};
    due_q.push_back(w);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      threshold_r    = THR_RESET;
      fine_r         = FINE_RESET;
      medium_r       = MEDIUM_RESET;
      coarse_r       = COARSE_RESET;
      value_r        = '0;
      sel_r          = SEL_FINE;
      settle_r       = '0;
      sent_r         = {1'b1, {VALUE_BITS{1'b0}}};
      mismatch_count = 0;
      due_q.delete();
    end else begin
      // results first: a word accepted now cannot stem from this edge's event
      if (out_valid && !out_stall) begin
        got = {serial_valid, serial_bit, last, setpoint, step_index};
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result word valid=%0b bit=%0b last=%0b setpoint=%0d step=%0d",
                   $time, got.carries_bit, got.data_bit, got.closes, got.value, got.sel);
          mismatch_count++;
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected valid=%0b bit=%0b last=%0b setpoint=%0d step=%0d",
                     $time, want.carries_bit, want.data_bit, want.closes, want.value,
                     want.sel);
            $display("%0t:          actual   valid=%0b bit=%0b last=%0b setpoint=%0d step=%0d",
                     $time, got.carries_bit, got.data_bit, got.closes, got.value, got.sel);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: threshold_r = cfg_data[THR_W-1:0];
          REG_FINE:      fine_r      = cfg_data[VALUE_BITS-1:0];
          REG_MEDIUM:    medium_r    = cfg_data[VALUE_BITS-1:0];
          REG_COARSE:    coarse_r    = cfg_data[VALUE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) apply_event(operation, phase_a, phase_b);
    end
    words_due = due_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus, clock, reset and verdict for the setpoint shifter;
// instantiates the block and setpoint_shift_checker, needs essp_pkg
module tb_top;
  import essp_pkg::*;

  localparam int         QUIET_LIMIT = 4000;
  localparam int         HOLD_CYCLES = 150;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            operation;
  logic                  phase_a;
  logic                  phase_b;
  logic                  out_valid;
  logic                  out_stall;
  logic                  serial_valid;
  logic                  serial_bit;
  logic                  last;
  logic [VALUE_BITS-1:0] setpoint;
  logic [1:0]            step_index;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  int                    mismatch_count;
  int                    words_due;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int quiet_cycles;

  encoder_stepped_setpoint_shifter_top dut (.*);
  setpoint_shift_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // no progress on either channel for too long means the block has hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic offer(input logic [1:0] op, input logic a, input logic b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      operation <= 2'($urandom);
      phase_a   <= 1'($urandom);
      phase_b   <= 1'($urandom);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    phase_a   <= a;
    phase_b   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic ticks(input int n);
    repeat (n) offer(OP_TICK, 1'($urandom), 1'($urandom));
  endtask

  // bursts of knob activity, each followed by enough ticks to settle and send
  task automatic random_items(input int count, input int send_ticks);
    int done;
    int r;
    int k;
    done = 0;
    while (done < count) begin
      k = $urandom_range(1, 5);
      repeat (k) begin
        r = $urandom_range(99);
        if (r < 75)      offer(OP_EDGE, 1'($urandom), 1'($urandom));
        else if (r < 92) offer(OP_BUTTON, 1'($urandom), 1'($urandom));
        else if (r < 96) offer(OP_TICK, 1'($urandom), 1'($urandom));
        else             offer(OP_UNUSED, 1'($urandom), 1'($urandom));
      end
      done = done + k;
      k = send_ticks + $urandom_range(0, 1);
      ticks(k);
      done = done + k;
    end
  endtask

  initial begin
    int thr;
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = OP_EDGE;
    phase_a       = 1'b0;
    phase_b       = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_THRESHOLD;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: first send with nothing sent yet, clamping, every selection
    write_reg(REG_THRESHOLD, 0);
    offer(OP_TICK, 1'b0, 1'b0);
    offer(OP_TICK, 1'b1, 1'b1);
    offer(OP_EDGE, 1'b0, 1'b1);
    offer(OP_EDGE, 1'b1, 1'b1);
    offer(OP_EDGE, 1'b0, 1'b0);
    offer(OP_EDGE, 1'b1, 1'b0);
    offer(OP_BUTTON, 1'b0, 1'b0);
    offer(OP_EDGE, 1'b0, 1'b0);
    offer(OP_BUTTON, 1'b1, 1'b0);
    offer(OP_EDGE, 1'b1, 1'b1);
    offer(OP_BUTTON, 1'b0, 1'b1);
    offer(OP_UNUSED, 1'b1, 1'b1);
    offer(OP_TICK, 1'b0, 1'b0);
    drain();
    // climb to the top of the range and send all ones
    write_reg(REG_FINE, 3984);
    offer(OP_EDGE, 1'b0, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0);
    offer(OP_EDGE, 1'b1, 1'b1);
    drain();
    write_reg(REG_FINE, 4095);
    offer(OP_EDGE, 1'b1, 1'b1);
    offer(OP_EDGE, 1'b0, 1'b1);
    offer(OP_TICK, 1'b1, 1'b0);
    drain();
    // a zero step still counts as a move
    write_reg(REG_FINE, 0);
    offer(OP_EDGE, 1'b1, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0);
    drain();

    // random, slow receiver
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_FINE, 1);
    write_reg(REG_MEDIUM, $urandom_range(2, 300));
    write_reg(REG_COARSE, 4095);
    send_idle_pct = 34;
    recv_idle_pct = 75;
    random_items(18, 1);
    hold_req = 1'b1;
    random_items(18, 1);
    drain();
    random_items(12, 1);
    drain();

    // random, slow sender
    thr = $urandom_range(1, 5);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_FINE, 0);
    write_reg(REG_MEDIUM, $urandom_range(1, 4095));
    write_reg(REG_COARSE, $urandom_range(50, 700));
    send_idle_pct = 75;
    recv_idle_pct = 34;
    random_items(40, thr + 1);
    drain();

    // random, full rate both ways
    write_reg(REG_THRESHOLD, 2);
    write_reg(REG_FINE, 7);
    write_reg(REG_MEDIUM, 64);
    write_reg(REG_COARSE, 512);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(40, 3);
    drain();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
